@@ hdl/bitfield_pixel_premultiply_macros.svh @@
// Assertion macros for the bit-field pixel premultiply block.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef BITFIELD_PIXEL_PREMULTIPLY_MACROS_SVH
`define BITFIELD_PIXEL_PREMULTIPLY_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define BPP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpp assertion failed");
// Next-cycle implication, checked out of reset
`define BPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpp assertion failed");
`else
`define BPP_ASSERT_NOW(label, ante, cons)
`define BPP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hdl/bpp_pkg.sv @@
// Shared types, register codes and helper functions for the pixel premultiply block.
// No dependencies; the RTL modules of the block refer to it by scoped names.
`timescale 1ns / 1ps

package bpp_pkg;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [31:0] RED_MASK_RST   = 32'h00FF_0000;
  localparam logic [31:0] GREEN_MASK_RST = 32'h0000_FF00;
  localparam logic [31:0] BLUE_MASK_RST  = 32'h0000_00FF;
  localparam logic [31:0] ALPHA_MASK_RST = 32'hFF00_0000;
  localparam logic [31:0] LOW_HALF_MASK  = 32'h0000_FFFF;
  localparam logic [7:0]  ALPHA_OPAQUE   = 8'hFF;
  localparam logic [7:0]  ALPHA_CLEAR    = 8'h00;
  localparam logic [15:0] ROUND_HALF     = 16'd128;

  // Register word index (byte address bits 4:2)
  typedef enum logic [2:0] {
    REG_RED_MASK   = 3'd0,
    REG_GREEN_MASK = 3'd1,
    REG_BLUE_MASK  = 3'd2,
    REG_ALPHA_MASK = 3'd3,
    REG_SIXTEEN    = 3'd4
  } bpp_reg_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        first_of_image;
    logic        last_of_image;
  } bpp_in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic [7:0] alpha_out;
    logic       any_visible;
    logic       any_transparent;
    logic       keep_image;
  } bpp_out_t;

  // One channel's mask with its precomputed alignment shift
  typedef struct packed {
    logic [31:0] mask;
    logic [4:0]  shift;
    logic        zero;
  } bpp_chan_cfg_t;

  typedef struct packed {
    bpp_chan_cfg_t red;
    bpp_chan_cfg_t green;
    bpp_chan_cfg_t blue;
    bpp_chan_cfg_t alpha;
    logic          sixteen;
  } bpp_cfg_t;

  // Count leading zeros of a mask in five halving steps (zero mask gives 31)
  function automatic logic [4:0] lead_zeros(input logic [31:0] m);
    logic [31:0] v;
    logic [4:0]  n;
    v = m;
    n = '0;
    if (v[31:16] == 16'h0) begin
      n[4] = 1'b1;
      v    = {v[15:0], 16'h0};
    end
    if (v[31:24] == 8'h0) begin
      n[3] = 1'b1;
      v    = {v[23:0], 8'h0};
    end
    if (v[31:28] == 4'h0) begin
      n[2] = 1'b1;
      v    = {v[27:0], 4'h0};
    end
    if (v[31:30] == 2'h0) begin
      n[1] = 1'b1;
      v    = {v[29:0], 2'h0};
    end
    if (v[31] == 1'b0) begin
      n[0] = 1'b1;
    end
    return n;
  endfunction

endpackage

@@ hdl/bpp_cfg_regs.sv @@
// Configuration register file: APB-style write/read of the four masks and the 16 bpp mode.
// Depends on bpp_pkg; loads each mask's alignment shift from the write data with the mask.
`timescale 1ns / 1ps

module bpp_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpp_pkg::CFG_AW-1:0]  paddr,
  input  logic [bpp_pkg::CFG_DW-1:0]  pwdata,
  output logic [bpp_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output bpp_pkg::bpp_cfg_t           cfg
);

  logic [31:0]       red_r, green_r, blue_r, alpha_r;
  logic              sixteen_r;
  logic [4:0]        red_sh_r, green_sh_r, blue_sh_r, alpha_sh_r;
  logic              wr_en;
  bpp_pkg::bpp_reg_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = bpp_pkg::bpp_reg_t'(paddr[4:2]);

  // Write the addressed register; a mask and its leading-zero count load together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r      <= bpp_pkg::RED_MASK_RST;
      green_r    <= bpp_pkg::GREEN_MASK_RST;
      blue_r     <= bpp_pkg::BLUE_MASK_RST;
      alpha_r    <= bpp_pkg::ALPHA_MASK_RST;
      sixteen_r  <= 1'b0;
      red_sh_r   <= bpp_pkg::lead_zeros(bpp_pkg::RED_MASK_RST);
      green_sh_r <= bpp_pkg::lead_zeros(bpp_pkg::GREEN_MASK_RST);
      blue_sh_r  <= bpp_pkg::lead_zeros(bpp_pkg::BLUE_MASK_RST);
      alpha_sh_r <= bpp_pkg::lead_zeros(bpp_pkg::ALPHA_MASK_RST);
    end else if (wr_en) begin
      unique case (idx)
        bpp_pkg::REG_RED_MASK: begin
          red_r    <= pwdata;
          red_sh_r <= bpp_pkg::lead_zeros(pwdata);
        end
        bpp_pkg::REG_GREEN_MASK: begin
          green_r    <= pwdata;
          green_sh_r <= bpp_pkg::lead_zeros(pwdata);
        end
        bpp_pkg::REG_BLUE_MASK: begin
          blue_r    <= pwdata;
          blue_sh_r <= bpp_pkg::lead_zeros(pwdata);
        end
        bpp_pkg::REG_ALPHA_MASK: begin
          alpha_r    <= pwdata;
          alpha_sh_r <= bpp_pkg::lead_zeros(pwdata);
        end
        bpp_pkg::REG_SIXTEEN:    sixteen_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (idx)
      bpp_pkg::REG_RED_MASK:   prdata = red_r;
      bpp_pkg::REG_GREEN_MASK: prdata = green_r;
      bpp_pkg::REG_BLUE_MASK:  prdata = blue_r;
      bpp_pkg::REG_ALPHA_MASK: prdata = alpha_r;
      bpp_pkg::REG_SIXTEEN:    prdata = {{(bpp_pkg::CFG_DW-1){1'b0}}, sixteen_r};
      default:                 prdata = '0;
    endcase
  end

  assign cfg.red     = '{mask: red_r,   shift: red_sh_r,   zero: (red_r == 32'h0)};
  assign cfg.green   = '{mask: green_r, shift: green_sh_r, zero: (green_r == 32'h0)};
  assign cfg.blue    = '{mask: blue_r,  shift: blue_sh_r,  zero: (blue_r == 32'h0)};
  assign cfg.alpha   = '{mask: alpha_r, shift: alpha_sh_r, zero: (alpha_r == 32'h0)};
  assign cfg.sixteen = sixteen_r;

endmodule

@@ hdl/bpp_chan_extract.sv @@
// Channel extractor: masks the pixel, aligns the mask's top bit to bit 31, takes the top byte.
// Depends on bpp_pkg for the channel configuration struct.
`timescale 1ns / 1ps

module bpp_chan_extract (
  input  logic [31:0]            pixel,
  input  bpp_pkg::bpp_chan_cfg_t chan,
  output logic [7:0]             value
);

  logic [31:0] aligned;

  // Shift by the precomputed leading-zero count of the mask
  assign aligned = (pixel & chan.mask) << chan.shift;
  assign value   = chan.zero ? 8'h00 : aligned[31:24];

endmodule

@@ hdl/bpp_premul.sv @@
// Premultiplier: scales one 8-bit color by alpha with a rounding divide by 255.
// Depends on bpp_pkg for the rounding constant.
`timescale 1ns / 1ps

module bpp_premul (
  input  logic [7:0] color,
  input  logic [7:0] alpha,
  output logic [7:0] result
);

  logic [15:0] prod;
  logic [15:0] sum;

  // t = c*a + 128 fits 16 bits; (t + (t >> 8)) >> 8 also stays below 2^16
  assign prod   = (16'(color) * 16'(alpha)) + bpp_pkg::ROUND_HALF;
  assign sum    = prod + {8'h00, prod[15:8]};
  assign result = sum[15:8];

endmodule

@@ hdl/bitfield_pixel_premultiply.sv @@
// Bit-field pixel unpack with alpha premultiply: top level.
// Depends on bpp_pkg, bpp_cfg_regs, bpp_chan_extract, bpp_premul and the assertion macros.
//
// Usage:
//   in_valid/in_stall/in_data carry one pixel word per beat, with first/last-of-image
//   marks. out_valid/out_stall/out_data carry one result per pixel: premultiplied
//   blue, green, red, the extracted alpha, the sticky visible/transparent flags and
//   keep_image (set only on the last pixel when both flags are set).
//   The cfg_ APB port holds the four channel masks (byte addresses 0x0..0xC) and the
//   16 bpp mode bit (0x10); pready is always high. Write it only while no pixel is in
//   flight; a mask and its alignment shift take effect at the same edge.
// Timing:
//   An accepted pixel goes from the input register through one pass of mask/shift/multiply
//   logic into the result register. Input register, logic and result register sustain
//   one pixel per clock while out_stall is low. A skid register behind the result
//   register takes a beat while a result waits; in_stall is the registered skid-full
//   flag, so it stays high after out_stall drops until the skid register empties.
// Reset:
//   rst_n (synchronous, active low) empties the pipeline, clears both sticky flags and
//   loads the 32 bpp default masks (red 0x00FF0000, green 0x0000FF00, blue 0x000000FF,
//   alpha 0xFF000000) with 16 bpp mode off.
`timescale 1ns / 1ps
`include "bitfield_pixel_premultiply_macros.svh"

module bitfield_pixel_premultiply (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bpp_pkg::bpp_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bpp_pkg::bpp_out_t           out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [bpp_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [bpp_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [bpp_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  bpp_pkg::bpp_cfg_t cfg;

  logic              s1_valid_r, s1_valid_nxt;
  bpp_pkg::bpp_in_t  s1_data_r;
  logic              out_valid_r, out_valid_nxt;
  bpp_pkg::bpp_out_t out_data_r;
  logic              skid_valid_r, skid_valid_nxt;
  bpp_pkg::bpp_out_t skid_data_r;
  logic              vis_r, vis_nxt;
  logic              trn_r, trn_nxt;

  logic              in_acc, out_acc, s1_move;
  logic              out_load_res, out_load_skid, skid_load;
  logic [31:0]       px;
  logic [7:0]        a_raw, r_raw, g_raw, b_raw;
  logic [7:0]        r_pm, g_pm, b_pm;
  bpp_pkg::bpp_out_t res;

  bpp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Handshake and pipeline movement
  assign in_stall      = skid_valid_r;
  assign in_acc        = in_valid && !in_stall;
  assign out_acc       = out_valid_r && !out_stall;
  assign s1_move       = s1_valid_r && (!skid_valid_r || out_acc);
  assign out_load_res  = s1_move && (!out_valid_r || (out_acc && !skid_valid_r));
  assign out_load_skid = out_acc && skid_valid_r;
  assign skid_load     = s1_move && !out_load_res;

  assign s1_valid_nxt   = in_acc || (s1_valid_r && !s1_move);
  assign out_valid_nxt  = out_load_res || out_load_skid || (out_valid_r && !out_acc);
  assign skid_valid_nxt = skid_load || (skid_valid_r && !out_acc);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
  end

  // Channel extraction on the (optionally 16 bpp) pixel word
  assign px = cfg.sixteen ? (s1_data_r.pixel & bpp_pkg::LOW_HALF_MASK) : s1_data_r.pixel;

  bpp_chan_extract u_ext_a (.pixel(px), .chan(cfg.alpha), .value(a_raw));
  bpp_chan_extract u_ext_r (.pixel(px), .chan(cfg.red),   .value(r_raw));
  bpp_chan_extract u_ext_g (.pixel(px), .chan(cfg.green), .value(g_raw));
  bpp_chan_extract u_ext_b (.pixel(px), .chan(cfg.blue),  .value(b_raw));

  // Premultiply; a zero alpha mask yields alpha 0 and hence zero colors
  bpp_premul u_pm_r (.color(r_raw), .alpha(a_raw), .result(r_pm));
  bpp_premul u_pm_g (.color(g_raw), .alpha(a_raw), .result(g_pm));
  bpp_premul u_pm_b (.color(b_raw), .alpha(a_raw), .result(b_pm));

  // Sticky flags: clear on first pixel, update only when an alpha mask is set
  always_comb begin
    vis_nxt = s1_data_r.first_of_image ? 1'b0 : vis_r;
    trn_nxt = s1_data_r.first_of_image ? 1'b0 : trn_r;
    if (!cfg.alpha.zero) begin
      if (a_raw != bpp_pkg::ALPHA_CLEAR) begin
        vis_nxt = 1'b1;
      end
      if (a_raw != bpp_pkg::ALPHA_OPAQUE) begin
        trn_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    res.blue_out        = b_pm;
    res.green_out       = g_pm;
    res.red_out         = r_pm;
    res.alpha_out       = a_raw;
    res.any_visible     = vis_nxt;
    res.any_transparent = trn_nxt;
    res.keep_image      = s1_data_r.last_of_image && vis_nxt && trn_nxt;
  end

  // Advance the sticky state as each pixel leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_r <= 1'b0;
      trn_r <= 1'b0;
    end else if (s1_move) begin
      vis_r <= vis_nxt;
      trn_r <= trn_nxt;
    end
  end

  // Result register and skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_res) begin
      out_data_r <= res;
    end else if (out_load_skid) begin
      out_data_r <= skid_data_r;
    end
    if (skid_load) begin
      skid_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `BPP_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r)
  `BPP_ASSERT_NEXT(a_skid_fills_on_stall,
                   out_valid_r && out_stall && !skid_valid_r && s1_valid_r,
                   skid_valid_r)
  `BPP_ASSERT_NOW(a_keep_needs_flags, out_valid_r && out_data_r.keep_image,
                  out_data_r.any_visible && out_data_r.any_transparent)
  `BPP_ASSERT_NEXT(a_result_follows_move, s1_move, out_valid_r)

endmodule

@@ bench/tb_bitfield_pixel_premultiply.sv @@
// Self-checking bench for bitfield_pixel_premultiply: bursty pixel beats, random output stalls.
// Holds its own mask/premultiply predictor and sticky-flag state; needs bpp_pkg and the RTL.
`timescale 1ns / 1ps

module tb_bitfield_pixel_premultiply;
  import bpp_pkg::*;

  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          PHASE_PIXELS = 200;
  localparam logic [31:0] RGB555_RED   = 32'h0000_7C00;
  localparam logic [31:0] RGB555_GREEN = 32'h0000_03E0;
  localparam logic [31:0] RGB555_BLUE  = 32'h0000_001F;
  localparam logic [31:0] RGB555_ALPHA = 32'h0000_8000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  bpp_in_t             in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  bpp_out_t            out_data;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr = '0;
  logic [CFG_DW-1:0]   cfg_pwdata = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  // Shadow of the mask registers and the sticky flags
  logic [31:0] mask_red   = RED_MASK_RST;
  logic [31:0] mask_green = GREEN_MASK_RST;
  logic [31:0] mask_blue  = BLUE_MASK_RST;
  logic [31:0] mask_alpha = ALPHA_MASK_RST;
  logic        sixteen_on = 1'b0;
  logic        seen_vis = 1'b0;
  logic        seen_tr = 1'b0;

  bpp_in_t  pending_pixels[$];
  bpp_out_t expected_results[$];
  bpp_out_t want;

  int  cycles = 0;
  int  err_cnt = 0;
  int  pixels_in = 0;
  int  results_ok = 0;
  int  kept_images = 0;
  int  mask_sets = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  hold_left = 0;
  int  rx_phase = 0;
  int  rx_mode = 0;
  bit  beat_taken = 1'b0;
  bit  hold_req = 1'b0;

  bitfield_pixel_premultiply u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Align the masked field to bit 31 and take the top byte
  function automatic logic [7:0] field_byte(logic [31:0] word, logic [31:0] mask);
    logic [31:0] v;
    logic [31:0] m;
    v = word & mask;
    m = mask;
    if (m == 32'h0) return 8'h00;
    while (!m[31]) begin
      v = v << 1;
      m = m << 1;
    end
    return v[31:24];
  endfunction

  // Rounding divide by 255 of channel times alpha
  function automatic logic [7:0] scale_by_alpha(logic [7:0] c, logic [7:0] a);
    logic [31:0] t;
    t = 32'(c) * 32'(a) + 32'(ROUND_HALF);
    t = (t + (t >> 8)) >> 8;
    return t[7:0];
  endfunction

  // Premultiplied pixel for one beat; advances the sticky flags
  function automatic bpp_out_t premultiplied_pixel(bpp_in_t item);
    logic [31:0] px;
    bpp_out_t    res;
    px = item.pixel;
    if (sixteen_on) px = px & LOW_HALF_MASK;
    if (item.first_of_image) begin
      seen_vis = 1'b0;
      seen_tr  = 1'b0;
    end
    res = '0;
    if (mask_alpha != 32'h0) begin
      res.alpha_out = field_byte(px, mask_alpha);
      if (res.alpha_out != ALPHA_CLEAR) seen_vis = 1'b1;
      if (res.alpha_out != ALPHA_OPAQUE) seen_tr = 1'b1;
      res.blue_out  = scale_by_alpha(field_byte(px, mask_blue), res.alpha_out);
      res.green_out = scale_by_alpha(field_byte(px, mask_green), res.alpha_out);
      res.red_out   = scale_by_alpha(field_byte(px, mask_red), res.alpha_out);
    end
    res.any_visible     = seen_vis;
    res.any_transparent = seen_tr;
    res.keep_image      = item.last_of_image & seen_vis & seen_tr;
    return res;
  endfunction

  // Mask picker: empty, full, random word or a contiguous field
  function automatic logic [31:0] rand_mask(bit narrow);
    logic [31:0] m;
    int          w;
    int          lsb;
    case ($urandom_range(0, 5))
      0: m = 32'h0;
      1: m = 32'hFFFF_FFFF;
      2: m = $urandom;
      default: begin
        w   = $urandom_range(1, 32);
        lsb = $urandom_range(0, 32 - w);
        m   = (w == 32) ? 32'hFFFF_FFFF : (((32'h1 << w) - 32'h1) << lsb);
      end
    endcase
    if (narrow && $urandom_range(0, 3) != 0) m = m & LOW_HALF_MASK;
    return m;
  endfunction

  // APB write, then read back the same register
  task automatic reg_write(input bpp_reg_t idx, input logic [31:0] val);
    logic [31:0] readback;
    readback = (idx == REG_SIXTEEN) ? {31'h0, val[0]} : val;
    case (idx)
      REG_RED_MASK:   mask_red   = val;
      REG_GREEN_MASK: mask_green = val;
      REG_BLUE_MASK:  mask_blue  = val;
      REG_ALPHA_MASK: mask_alpha = val;
      REG_SIXTEEN:    sixteen_on = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== readback) begin
      $display("%0t register %s readback: expected %h, got %h",
               $realtime, idx.name(), readback, cfg_prdata);
      err_cnt++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_masks(input logic [31:0] r, input logic [31:0] g, input logic [31:0] b,
                           input logic [31:0] a, input logic s);
    reg_write(REG_RED_MASK, r);
    reg_write(REG_GREEN_MASK, g);
    reg_write(REG_BLUE_MASK, b);
    reg_write(REG_ALPHA_MASK, a);
    reg_write(REG_SIXTEEN, {31'h0, s});
    mask_sets++;
    // let the alignment shifts settle
    repeat (3) @(negedge clk);
  endtask

  task automatic add_pixel(input logic [31:0] px, input logic first, input logic last);
    bpp_in_t item;
    item.pixel          = px;
    item.first_of_image = first;
    item.last_of_image  = last;
    pending_pixels.push_back(item);
  endtask

  // One image of random pixels; untidy images get random first/last marks
  task automatic add_image(input int len, input bit tidy);
    logic [31:0] px;
    logic        first;
    logic        last;
    for (int i = 0; i < len; i++) begin
      px = $urandom;
      case ($urandom_range(0, 3))
        0: px = px | mask_alpha;
        1: px = px & ~mask_alpha;
        default: ;
      endcase
      first = tidy ? (i == 0) : 1'($urandom_range(0, 1));
      last  = tidy ? (i == len - 1) : 1'($urandom_range(0, 1));
      add_pixel(px, first, last);
    end
  endtask

  // Hold off new work until every beat is in and every result is out
  task automatic drain();
    while (pending_pixels.size() != 0 || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Sender: bursts of beats separated by random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_valid || beat_taken)) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_pixels[0];
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 9))
            0, 1, 2: gap_left = 0;
            3:       gap_left = $urandom_range(15, 40);
            default: gap_left = $urandom_range(1, 6);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern changes each time rx_phase wraps; long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 150;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      rx_phase++;
      if (rx_phase >= 64) begin
        rx_phase = 0;
        rx_mode  = $urandom_range(0, 3);
      end
      case (rx_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= rx_phase[0];
      endcase
    end
  end

  // Accept beats into the predictor, check results against the oldest expectation
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $realtime, expected_results.size());
      $display("TB_ERROR");
      $finish;
    end else if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(premultiplied_pixel(in_data));
        void'(pending_pixels.pop_front());
        beat_taken = 1'b1;
        pixels_in++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result beat: got %p", $realtime, out_data);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            $display("%0t result mismatch: expected b=%h g=%h r=%h a=%h vis=%b tr=%b keep=%b",
                     $realtime, want.blue_out, want.green_out, want.red_out, want.alpha_out,
                     want.any_visible, want.any_transparent, want.keep_image);
            $display("%0t                     got b=%h g=%h r=%h a=%h vis=%b tr=%b keep=%b",
                     $realtime, out_data.blue_out, out_data.green_out, out_data.red_out,
                     out_data.alpha_out, out_data.any_visible, out_data.any_transparent,
                     out_data.keep_image);
            err_cnt++;
          end else begin
            results_ok++;
            if (want.keep_image) kept_images++;
          end
        end
      end
    end
  end

  // Stimulus: directed corners per mask setting, then random images
  initial begin
    int queued;
    int len;
    bit narrow;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default 32 bpp masks: clear, opaque, partial alpha, first and last together
    set_masks(RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST, ALPHA_MASK_RST, 1'b0);
    add_pixel(32'h0000_0000, 1'b1, 1'b0);
    add_pixel(32'hFFFF_FFFF, 1'b0, 1'b0);
    add_pixel(32'h80FF_8001, 1'b0, 1'b1);
    add_pixel(32'h7F12_3456, 1'b1, 1'b1);
    add_pixel(32'hFF00_0000, 1'b1, 1'b1);
    add_pixel(32'h00FF_FFFF, 1'b1, 1'b1);
    drain();

    // 16 bpp: upper half forced to zero, single-bit alpha
    set_masks(RGB555_RED, RGB555_GREEN, RGB555_BLUE, RGB555_ALPHA, 1'b1);
    add_pixel(32'hFFFF_7FFF, 1'b1, 1'b0);
    add_pixel(32'h0000_FFFF, 1'b0, 1'b1);
    add_pixel(32'hFFFF_8000, 1'b1, 1'b1);
    drain();

    // zero alpha mask leaves the flags alone; zero red mask
    set_masks(32'h0, GREEN_MASK_RST, BLUE_MASK_RST, 32'h0, 1'b0);
    add_pixel(32'hFFFF_FFFF, 1'b1, 1'b0);
    add_pixel(32'h1234_5678, 1'b0, 1'b1);
    drain();

    // scattered masks and an alpha bit at the bottom
    set_masks(32'hFFFF_FFFF, 32'h8000_0001, 32'h0, 32'h0000_0001, 1'b0);
    add_pixel(32'hFFFF_FFFF, 1'b1, 1'b0);
    add_pixel(32'h8000_0001, 1'b0, 1'b0);
    add_pixel(32'h0000_0000, 1'b0, 1'b1);
    add_pixel(32'h7FFF_FFFE, 1'b1, 1'b1);
    drain();

    // every mask full width
    set_masks(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_pixel(32'hFFFF_FFFF, 1'b1, 1'b0);
    add_pixel(32'h0000_0000, 1'b0, 1'b1);
    add_pixel(32'hA5A5_A5A5, 1'b1, 1'b1);
    drain();

    // random images, mostly well formed, one mask setting per phase
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_masks(RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST, ALPHA_MASK_RST, 1'b0);
        1: set_masks(RGB555_RED, RGB555_GREEN, RGB555_BLUE, RGB555_ALPHA, 1'b1);
        default: begin
          narrow = 1'($urandom_range(0, 1));
          set_masks(rand_mask(narrow), rand_mask(narrow), rand_mask(narrow),
                    rand_mask(narrow), narrow);
        end
      endcase
      // back up the pipeline once while the sender keeps offering beats
      if (ph == 2) hold_req = 1'b1;
      queued = 0;
      while (queued < PHASE_PIXELS) begin
        len = $urandom_range(1, 24);
        add_image(len, $urandom_range(0, 6) != 0);
        queued += len;
      end
      drain();
    end

    repeat (10) @(negedge clk);
    $display("Checked %0d of %0d pixels over %0d mask settings; %0d images flagged to keep.",
             results_ok, pixels_in, mask_sets, kept_images);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
